@@ sv/eti_dfr_pkg.sv @@
`timescale 1ns / 1ps
// shared types and constants for the eti stream deframer
// no dependencies
package eti_dfr_pkg;

  localparam int unsigned HIST_W = 48;
  localparam int unsigned PAD_W  = 13;

  localparam logic [31:0] SYNC_A = 32'h49c5f8ff;
  localparam logic [31:0] SYNC_B = 32'hb63a07ff;

  typedef enum logic [2:0] {
    ST_IDENTIFIED  = 3'd0,
    ST_FRAME_BYTE  = 3'd1,
    ST_EMPTY_FRAME = 3'd2,
    ST_NO_SYNC     = 3'd3,
    ST_HDR_TRUNC   = 3'd4,
    ST_SIZE_LARGE  = 3'd5,
    ST_INCOMPLETE  = 3'd6,
    ST_CLEAN_END   = 3'd7
  } status_t;

  typedef enum logic [1:0] {
    KIND_NONE     = 2'd0,
    KIND_RAW      = 2'd1,
    KIND_STREAMED = 2'd2,
    KIND_FRAMED   = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    S_IDENTIFY,
    S_LEN_LO,
    S_LEN_HI,
    S_DATA,
    S_HALT
  } phase_t;

  typedef struct packed {
    logic       mode;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    status_t          status;
    logic [7:0]       out_byte;
    logic             frame_last;
    logic [PAD_W-1:0] pad_count;
    kind_t            stream_kind;
  } out_item_t;

  // byte source select: input byte or a retained history byte
  typedef struct packed {
    logic       use_hist;
    logic [2:0] idx;
  } src_sel_t;

  typedef struct packed {
    logic    emit;
    status_t emit_status;
    logic    shift_hist;
    logic    set_kind;
    logic    load_lo;
    logic    load_len;
    logic    load_raw;
    logic    step_cnt;
  } ctrl_cmd_t;

  typedef struct packed {
    logic  out_free;
    kind_t id_kind;
    logic  exhausted;
    logic  hdr_lt10;
    logic  len_too_big;
    logic  len_zero;
    logic  data_last;
    logic  cnt_zero;
    logic  fmt_raw;
  } dp_status_t;

endpackage

@@ sv/eti_dfr_datapath.sv @@
`timescale 1ns / 1ps
// datapath: history window, sync match, length and byte counters, output register
// depends on eti_dfr_pkg
module eti_dfr_datapath #(
  parameter int unsigned MAX_FRAME_BYTES = 6144
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic [7:0]             data_byte,
  input  eti_dfr_pkg::src_sel_t  src,
  input  eti_dfr_pkg::ctrl_cmd_t cmd,
  output eti_dfr_pkg::dp_status_t st,
  input  logic                   out_ready,
  output logic                   out_valid,
  output eti_dfr_pkg::out_item_t out_data
);

  localparam int unsigned LW = $clog2(MAX_FRAME_BYTES + 1);
  localparam int unsigned HW = $clog2(MAX_FRAME_BYTES + 11);

  logic [eti_dfr_pkg::HIST_W-1:0] history;
  logic [HW-1:0]                  hdr_count;
  eti_dfr_pkg::kind_t             fmt;
  logic [7:0]                     len_lo;
  logic [LW-1:0]                  frame_length;
  logic [LW-1:0]                  frame_cnt;

  logic [7:0]                     byte_src;
  logic [eti_dfr_pkg::HIST_W-1:0] history_next;
  logic [31:0]                    sync_word;
  logic                           sync_hit;
  eti_dfr_pkg::kind_t             id_kind;
  logic [15:0]                    len16;
  logic [LW:0]                    cnt_plus;
  logic [eti_dfr_pkg::PAD_W-1:0]  pad_frame;
  logic [eti_dfr_pkg::PAD_W-1:0]  pad_full;
  eti_dfr_pkg::out_item_t         item_next;

  always_comb begin
    case (src.idx)
      3'd0:    byte_src = history[7:0];
      3'd1:    byte_src = history[15:8];
      3'd2:    byte_src = history[23:16];
      3'd3:    byte_src = history[31:24];
      3'd4:    byte_src = history[39:32];
      3'd5:    byte_src = history[47:40];
      default: byte_src = 8'h00;
    endcase
    if (!src.use_hist) begin
      byte_src = data_byte;
    end
  end

  assign history_next = {history[eti_dfr_pkg::HIST_W-9:0], byte_src};
  // newest byte is the top of the little-endian word
  assign sync_word = {history_next[7:0], history_next[15:8],
                      history_next[23:16], history_next[31:24]};
  assign sync_hit  = (sync_word == eti_dfr_pkg::SYNC_A) ||
                     (sync_word == eti_dfr_pkg::SYNC_B);

  always_comb begin
    id_kind = eti_dfr_pkg::KIND_NONE;
    if (sync_hit) begin
      if (hdr_count == HW'(3) ||
          (hdr_count >= HW'(10) && hdr_count < HW'(MAX_FRAME_BYTES + 10))) begin
        id_kind = eti_dfr_pkg::KIND_RAW;
      end else if (hdr_count == HW'(5)) begin
        id_kind = eti_dfr_pkg::KIND_STREAMED;
      end else if (hdr_count == HW'(9)) begin
        id_kind = eti_dfr_pkg::KIND_FRAMED;
      end
    end
  end

  assign len16    = {byte_src, len_lo};
  assign cnt_plus = {1'b0, frame_cnt} + (LW+1)'(1);

  assign st.id_kind     = id_kind;
  assign st.out_free    = !out_valid || out_ready;
  assign st.exhausted   = hdr_count >= HW'(MAX_FRAME_BYTES + 9);
  assign st.hdr_lt10    = hdr_count < HW'(10);
  assign st.len_too_big = len16 > 16'(MAX_FRAME_BYTES);
  assign st.len_zero    = len16 == 16'd0;
  assign st.data_last   = cnt_plus >= {1'b0, frame_length};
  assign st.cnt_zero    = frame_cnt == '0;
  assign st.fmt_raw     = fmt == eti_dfr_pkg::KIND_RAW;

  assign pad_frame = eti_dfr_pkg::PAD_W'(LW'(MAX_FRAME_BYTES) - frame_length);
  assign pad_full  = eti_dfr_pkg::PAD_W'(MAX_FRAME_BYTES);

  always_comb begin
    item_next.status      = cmd.emit_status;
    item_next.out_byte    = 8'h00;
    item_next.frame_last  = 1'b0;
    item_next.pad_count   = '0;
    item_next.stream_kind = cmd.set_kind ? id_kind : fmt;
    case (cmd.emit_status)
      eti_dfr_pkg::ST_FRAME_BYTE: begin
        item_next.out_byte   = byte_src;
        item_next.frame_last = st.data_last;
        item_next.pad_count  = st.data_last ? pad_frame : '0;
      end
      eti_dfr_pkg::ST_EMPTY_FRAME: begin
        item_next.frame_last = 1'b1;
        item_next.pad_count  = pad_full;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      history      <= '0;
      hdr_count    <= '0;
      fmt          <= eti_dfr_pkg::KIND_NONE;
      len_lo       <= '0;
      frame_length <= '0;
      frame_cnt    <= '0;
    end else begin
      if (cmd.shift_hist) begin
        history   <= history_next;
        hdr_count <= hdr_count + HW'(1);
      end
      if (cmd.set_kind) begin
        fmt <= id_kind;
      end
      if (cmd.load_lo) begin
        len_lo <= byte_src;
      end
      if (cmd.load_len) begin
        frame_length <= len16[LW-1:0];
        frame_cnt    <= '0;
      end else if (cmd.load_raw) begin
        frame_length <= LW'(MAX_FRAME_BYTES);
        frame_cnt    <= '0;
      end else if (cmd.step_cnt) begin
        frame_cnt <= st.data_last ? '0 : cnt_plus[LW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_data <= item_next;
    end
  end

endmodule

@@ sv/eti_dfr_ctrl.sv @@
`timescale 1ns / 1ps
// controller: format/frame phase machine and identification replay sequencing
// depends on eti_dfr_pkg
module eti_dfr_ctrl (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic                    mode,
  input  eti_dfr_pkg::dp_status_t st,
  output eti_dfr_pkg::src_sel_t   src,
  output eti_dfr_pkg::ctrl_cmd_t  cmd
);

  eti_dfr_pkg::phase_t state;
  eti_dfr_pkg::phase_t state_next;
  logic                replay;
  logic [2:0]          rep_idx;

  logic       acc;
  logic       rep_go;
  logic       ev;
  logic       fin;
  logic       rep_start;
  logic [2:0] rep_start_idx;

  assign in_ready     = !replay && st.out_free;
  assign acc          = in_valid && in_ready;
  assign rep_go       = replay && st.out_free;
  // a byte for the frame rule, from the input or from history
  assign ev           = (acc && !mode) || rep_go;
  assign fin          = acc && mode;
  assign src.use_hist = replay;
  assign src.idx      = rep_idx;

  always_comb begin
    state_next = state;
    case (state)
      eti_dfr_pkg::S_IDENTIFY: begin
        if (fin) begin
          state_next = eti_dfr_pkg::S_HALT;
        end else if (acc) begin
          if (st.id_kind == eti_dfr_pkg::KIND_RAW) begin
            state_next = eti_dfr_pkg::S_DATA;
          end else if (st.id_kind != eti_dfr_pkg::KIND_NONE) begin
            state_next = eti_dfr_pkg::S_LEN_LO;
          end else if (st.exhausted) begin
            state_next = eti_dfr_pkg::S_HALT;
          end
        end
      end
      eti_dfr_pkg::S_LEN_LO: begin
        if (fin) begin
          state_next = eti_dfr_pkg::S_HALT;
        end else if (ev) begin
          state_next = eti_dfr_pkg::S_LEN_HI;
        end
      end
      eti_dfr_pkg::S_LEN_HI: begin
        if (fin) begin
          state_next = eti_dfr_pkg::S_HALT;
        end else if (ev) begin
          if (st.len_too_big) begin
            state_next = eti_dfr_pkg::S_HALT;
          end else if (st.len_zero) begin
            state_next = eti_dfr_pkg::S_LEN_LO;
          end else begin
            state_next = eti_dfr_pkg::S_DATA;
          end
        end
      end
      eti_dfr_pkg::S_DATA: begin
        if (fin) begin
          state_next = eti_dfr_pkg::S_HALT;
        end else if (ev && st.data_last && !st.fmt_raw) begin
          state_next = eti_dfr_pkg::S_LEN_LO;
        end
      end
      eti_dfr_pkg::S_HALT: begin
        state_next = eti_dfr_pkg::S_HALT;
      end
      default: begin
        state_next = eti_dfr_pkg::S_HALT;
      end
    endcase
  end

  always_comb begin
    cmd           = '0;
    cmd.emit_status = eti_dfr_pkg::ST_IDENTIFIED;
    rep_start     = 1'b0;
    rep_start_idx = 3'd0;
    case (state)
      eti_dfr_pkg::S_IDENTIFY: begin
        if (fin) begin
          cmd.emit        = 1'b1;
          cmd.emit_status = st.hdr_lt10 ? eti_dfr_pkg::ST_HDR_TRUNC
                                        : eti_dfr_pkg::ST_NO_SYNC;
        end else if (acc) begin
          cmd.shift_hist = 1'b1;
          if (st.id_kind != eti_dfr_pkg::KIND_NONE) begin
            cmd.emit        = 1'b1;
            cmd.emit_status = eti_dfr_pkg::ST_IDENTIFIED;
            cmd.set_kind    = 1'b1;
            rep_start       = 1'b1;
            if (st.id_kind == eti_dfr_pkg::KIND_RAW) begin
              cmd.load_raw  = 1'b1;
              rep_start_idx = 3'd3;
            end else begin
              rep_start_idx = 3'd5;
            end
          end else if (st.exhausted) begin
            cmd.emit        = 1'b1;
            cmd.emit_status = eti_dfr_pkg::ST_NO_SYNC;
          end
        end
      end
      eti_dfr_pkg::S_LEN_LO: begin
        if (fin) begin
          cmd.emit        = 1'b1;
          cmd.emit_status = eti_dfr_pkg::ST_CLEAN_END;
        end else if (ev) begin
          cmd.load_lo = 1'b1;
        end
      end
      eti_dfr_pkg::S_LEN_HI: begin
        if (fin) begin
          cmd.emit        = 1'b1;
          cmd.emit_status = eti_dfr_pkg::ST_CLEAN_END;
        end else if (ev) begin
          if (st.len_too_big) begin
            cmd.emit        = 1'b1;
            cmd.emit_status = eti_dfr_pkg::ST_SIZE_LARGE;
          end else if (st.len_zero) begin
            cmd.emit        = 1'b1;
            cmd.emit_status = eti_dfr_pkg::ST_EMPTY_FRAME;
          end else begin
            cmd.load_len = 1'b1;
          end
        end
      end
      eti_dfr_pkg::S_DATA: begin
        if (fin) begin
          cmd.emit        = 1'b1;
          cmd.emit_status = (st.fmt_raw && st.cnt_zero) ? eti_dfr_pkg::ST_CLEAN_END
                                                        : eti_dfr_pkg::ST_INCOMPLETE;
        end else if (ev) begin
          cmd.emit        = 1'b1;
          cmd.emit_status = eti_dfr_pkg::ST_FRAME_BYTE;
          cmd.step_cnt    = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= eti_dfr_pkg::S_IDENTIFY;
      replay  <= 1'b0;
      rep_idx <= 3'd0;
    end else begin
      state <= state_next;
      if (rep_start) begin
        replay  <= 1'b1;
        rep_idx <= rep_start_idx;
      end else if (rep_go) begin
        // an oversize length during replay drops the rest
        if (rep_idx == 3'd0 || state_next == eti_dfr_pkg::S_HALT) begin
          replay <= 1'b0;
        end else begin
          rep_idx <= rep_idx - 3'd1;
        end
      end
    end
  end

`ifndef SYNTHESIS
  a_halt_sticky: assert property (@(posedge clk) disable iff (rst)
    state == eti_dfr_pkg::S_HALT |=> state == eti_dfr_pkg::S_HALT)
    else $error("halted controller left halt");

  a_replay_from_identify: assert property (@(posedge clk) disable iff (rst)
    $rose(replay) |-> $past(state) == eti_dfr_pkg::S_IDENTIFY)
    else $error("replay started outside identification");

  a_raw_no_length: assert property (@(posedge clk) disable iff (rst)
    (state == eti_dfr_pkg::S_LEN_LO || state == eti_dfr_pkg::S_LEN_HI) |-> !st.fmt_raw)
    else $error("raw stream entered length prefix phase");

  a_emit_has_room: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> st.out_free)
    else $error("result written into a full output register");
`endif

endmodule

@@ sv/eti_stream_deframer_core.sv @@
`timescale 1ns / 1ps
// top level of the eti stream deframer: controller plus datapath
// depends on eti_dfr_pkg, eti_dfr_ctrl, eti_dfr_datapath
//
// Byte-in, result-out deframer. One input request is taken per cycle
// while the one-entry output register is free or being drained, so a
// steady stream runs at one byte per cycle and each byte gives at most
// one result. When the format is identified the block emits the
// identified result on that byte and then replays the retained history
// through the same frame path, one byte per cycle while the output
// register is free, input stalled: 4 bytes for raw, 6 for streamed
// or framed, fewer if an oversize length halts the replay. Throughput
// is set by the single shared frame-rule path and the one-deep output
// register. After any error or end-of-stream result the block halts
// and accepts and drops every later request until reset.
module eti_stream_deframer_core #(
  parameter int unsigned MAX_FRAME_BYTES = 6144
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  eti_dfr_pkg::in_item_t  in_data,
  output logic                   out_valid,
  input  logic                   out_ready,
  output eti_dfr_pkg::out_item_t out_data
);

  eti_dfr_pkg::ctrl_cmd_t  cmd;
  eti_dfr_pkg::dp_status_t st;
  eti_dfr_pkg::src_sel_t   src;

  eti_dfr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .mode     (in_data.mode),
    .st       (st),
    .src      (src),
    .cmd      (cmd)
  );

  eti_dfr_datapath #(
    .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .data_byte (in_data.data_byte),
    .src       (src),
    .cmd       (cmd),
    .st        (st),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule
